@@ rtl/tcmm_pkg.sv @@
`default_nettype none

package tcmm_pkg;

    // physical and logical chunk space
    localparam int PHYS_CHUNKS    = 1024;
    localparam int LOGICAL_CHUNKS = 1024;
    localparam int PHYS_W         = $clog2(PHYS_CHUNKS);
    localparam int LOG_W          = $clog2(LOGICAL_CHUNKS);
    localparam int PTR_W          = $clog2(PHYS_CHUNKS + 1);
    localparam int CLR_DEPTH      = (PHYS_CHUNKS > LOGICAL_CHUNKS) ? PHYS_CHUNKS : LOGICAL_CHUNKS;
    localparam int CLR_W          = $clog2(CLR_DEPTH);

    // port field widths
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int TIER_W     = 2;
    localparam int LC_IN_W    = 10;
    localparam int PC_OUT_W   = 10;
    localparam int PAIR_W     = 32;
    localparam int NUM_PAIRS  = 9;
    localparam int SLOT_W     = 4;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    // register reset values
    localparam logic [CFG_W-1:0] FAST_RST  = CFG_W'(256);
    localparam logic [CFG_W-1:0] MID_RST   = CFG_W'(256);
    localparam logic [CFG_W-1:0] TOTAL_RST = CFG_W'(1024);

    // tier codes
    localparam logic [TIER_W-1:0] TIER_FAST = 2'd0;
    localparam logic [TIER_W-1:0] TIER_MID  = 2'd1;
    localparam logic [TIER_W-1:0] TIER_SLOW = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_SCAN,
        ST_FREE,
        ST_WRITE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic fwd_rd;
        logic scan_start;
        logic scan_step;
        logic set_full;
        logic free_old;
        logic write_new;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic same_tier;
        logic hit;
        logic exhausted;
        logic out_free;
    } status_t;

    // range end limited to the physical space
    function automatic logic [PTR_W-1:0] clamp_phys(input logic [CFG_W:0] v);
        logic [PTR_W-1:0] r;
        if (v > (CFG_W+1)'(PHYS_CHUNKS))
            r = PTR_W'(PHYS_CHUNKS);
        else
            r = v[PTR_W-1:0];
        return r;
    endfunction

    // tier code three is slow
    function automatic logic [TIER_W-1:0] fold_tier(input logic [TIER_W-1:0] t);
        logic [TIER_W-1:0] r;
        r = (t > TIER_SLOW) ? TIER_SLOW : t;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/tcmm_ctrl.sv @@
`default_nettype none

module tcmm_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output tcmm_pkg::cmd_t        cmd,
    input  tcmm_pkg::status_t     status,
    output logic                  in_ready
);
    import tcmm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (status.clr_last)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_valid)
                    state_next = ST_LOOKUP;
            ST_LOOKUP:
                state_next = ST_CHECK;
            ST_CHECK:
                state_next = status.same_tier ? ST_FINISH : ST_SCAN;
            ST_SCAN:
                if (status.hit)
                    state_next = ST_FREE;
                else if (status.exhausted)
                    state_next = ST_FINISH;
            ST_FREE:
                state_next = ST_WRITE;
            ST_WRITE:
                state_next = ST_FINISH;
            ST_FINISH:
                if (status.out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
                cmd.clr_step = 1'b1;
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_LOOKUP:
                cmd.fwd_rd = 1'b1;
            ST_CHECK:
                cmd.scan_start = !status.same_tier;
            ST_SCAN:
            begin
                cmd.scan_step = !status.hit && !status.exhausted;
                cmd.set_full  = !status.hit && status.exhausted;
            end
            ST_FREE:
                cmd.free_old = 1'b1;
            ST_WRITE:
                cmd.write_new = 1'b1;
            ST_FINISH:
                cmd.finish = status.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/tcmm_dp.sv @@
`default_nettype none

module tcmm_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  tcmm_pkg::cmd_t                      cmd,
    output tcmm_pkg::status_t                   status,
    input  wire logic [tcmm_pkg::IN_DATA_W-1:0] in_data,
    input  wire logic                           cfg_wr,
    input  wire logic [tcmm_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [tcmm_pkg::CFG_W-1:0]     cfg_val,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [tcmm_pkg::OUT_DATA_W-1:0]     out_data
);
    import tcmm_pkg::*;

    // tier bounds
    logic [CFG_W-1:0] fast_reg;
    logic [CFG_W-1:0] mid_reg;
    logic [CFG_W-1:0] total_reg;

    // storage, cleared by the sweep after reset
    logic [PHYS_W:0]  fwd_mem [LOGICAL_CHUNKS];
    logic             rev_mem [PHYS_CHUNKS];
    logic [PHYS_W:0]  fwd_q_reg;
    logic             rev_q_reg;
    logic [CLR_W-1:0] clr_ptr_reg;

    // request
    logic [LOG_W-1:0]  lc_reg;
    logic [TIER_W-1:0] cur_reg;
    logic [TIER_W-1:0] want_reg;
    logic              moved_reg;
    logic              full_reg;

    // scan
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  hi_reg;
    logic [PTR_W-1:0]  chk_addr_reg;
    logic              chk_valid_reg;
    logic              issue;

    logic [PAIR_W-1:0] cnt_reg [NUM_PAIRS];
    logic [PAIR_W-1:0] cnt_next;

    logic              out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [PTR_W-1:0]  lo;
    logic [PTR_W-1:0]  hi;
    logic [TIER_W-1:0] fin;
    logic [SLOT_W-1:0] slot;
    logic [PHYS_W-1:0] newp;
    logic [PC_OUT_W-1:0] pc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg  <= FAST_RST;
            mid_reg   <= MID_RST;
            total_reg <= TOTAL_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                CFG_FAST:  fast_reg  <= cfg_val;
                CFG_MID:   mid_reg   <= cfg_val;
                CFG_TOTAL: total_reg <= cfg_val;
                default:   ;
            endcase
        end
    end

    // target range of the wanted tier
    always_comb
    begin
        case (want_reg)
            TIER_FAST:
            begin
                lo = '0;
                hi = clamp_phys({1'b0, fast_reg});
            end
            TIER_MID:
            begin
                lo = clamp_phys({1'b0, fast_reg});
                hi = clamp_phys({1'b0, fast_reg} + {1'b0, mid_reg});
            end
            default:
            begin
                lo = clamp_phys({1'b0, fast_reg} + {1'b0, mid_reg});
                hi = clamp_phys({1'b0, total_reg});
            end
        endcase
    end

    assign issue = cmd.scan_step && (ptr_reg < hi_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_ptr_reg <= '0;
        else if (cmd.clr_step)
            clr_ptr_reg <= clr_ptr_reg + CLR_W'(1);
    end

    // forward map: valid bit on top, physical chunk below
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step && ({1'b0, clr_ptr_reg} < (CLR_W+1)'(LOGICAL_CHUNKS)))
            fwd_mem[clr_ptr_reg[LOG_W-1:0]] <= '0;
        else if (cmd.write_new)
            fwd_mem[lc_reg] <= {1'b1, newp};
        if (cmd.fwd_rd)
            fwd_q_reg <= fwd_mem[lc_reg];
    end

    // reverse map: used bit per physical chunk
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step && ({1'b0, clr_ptr_reg} < (CLR_W+1)'(PHYS_CHUNKS)))
            rev_mem[clr_ptr_reg[PHYS_W-1:0]] <= 1'b0;
        else if (cmd.free_old && fwd_q_reg[PHYS_W])
            rev_mem[fwd_q_reg[PHYS_W-1:0]] <= 1'b0;
        else if (cmd.write_new)
            rev_mem[newp] <= 1'b1;
        if (issue)
            rev_q_reg <= rev_mem[ptr_reg[PHYS_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            lc_reg   <= LOG_W'(in_data[LC_IN_W-1:0]);
            cur_reg  <= fold_tier(in_data[LC_IN_W +: TIER_W]);
            want_reg <= fold_tier(in_data[LC_IN_W+TIER_W +: TIER_W]);
        end
        if (cmd.scan_start)
        begin
            ptr_reg <= lo;
            hi_reg  <= hi;
        end
        else if (issue)
        begin
            ptr_reg      <= ptr_reg + PTR_W'(1);
            chk_addr_reg <= ptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg <= 1'b0;
            moved_reg     <= 1'b0;
            full_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
                chk_valid_reg <= 1'b0;
            else if (cmd.scan_step)
                chk_valid_reg <= issue;
            if (cmd.accept)
            begin
                moved_reg <= 1'b0;
                full_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.write_new)
                    moved_reg <= 1'b1;
                if (cmd.set_full)
                    full_reg <= 1'b1;
            end
        end
    end

    assign newp = chk_addr_reg[PHYS_W-1:0];
    assign fin  = full_reg ? cur_reg : want_reg;
    assign slot = SLOT_W'({2'b0, cur_reg} * 4'd3 + {2'b0, fin});
    assign cnt_next = cnt_reg[slot] + PAIR_W'(1);
    assign pc = moved_reg ? PC_OUT_W'(newp) :
                (fwd_q_reg[PHYS_W] ? PC_OUT_W'(fwd_q_reg[PHYS_W-1:0]) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PAIRS; i++)
                cnt_reg[i] <= '0;
        end
        else if (cmd.finish)
            cnt_reg[slot] <= cnt_next;
    end

    // output register, refilled as the last word is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            out_data_reg <= {2'b0, cnt_next, pc, full_reg, moved_reg, fin};
    end

    assign status.clr_last  = ({1'b0, clr_ptr_reg} == (CLR_W+1)'(CLR_DEPTH - 1));
    assign status.same_tier = (cur_reg == want_reg);
    assign status.hit       = chk_valid_reg && !rev_q_reg;
    assign status.exhausted = !chk_valid_reg && !(ptr_reg < hi_reg);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/tiered_chunk_migration_mapper_unit.sv @@
// one request at a time: accept, lookup and check, then a first-free scan
// over the N entries of the target range up to the first free entry, a map
// update (free old entry, write new) and the result; a same-tier request skips
// the scan and update, and a full range skips the update
// after reset a sweep clears both map memories; requests wait,
// configuration writes are taken throughout
`default_nettype none

module tiered_chunk_migration_mapper_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // request words
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // logical_chunk[9:0], current_tier[11:10], wanted_tier[13:12], zero fill
    input  wire logic [tcmm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // result words
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // final_tier[1:0], moved[2], tier_full[3], physical_chunk[13:4],
    // pair_count[45:14], zero fill
    output logic [tcmm_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // register writes: 0 fast_tier_chunks, 1 mid_tier_chunks, 2 total_chunks
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tcmm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tcmm_pkg::CFG_W-1:0]        cfg_data
);
    import tcmm_pkg::*;

    cmd_t    cmd;
    status_t status;

    // registers are always writable
    assign cfg_ready = 1'b1;

    // sequencer: clear sweep, lookup, scan, map update, result
    tcmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .cmd      (cmd),
        .status   (status),
        .in_ready (s_axis_tready)
    );

    // maps, scan pointer, pair counters and result register
    tcmm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .cfg_wr    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_val   (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire
